/* src/ogi_pkg.sv */
// Shared types, constants and helper functions for the occupancy grid inflation block.
// No dependencies; design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package ogi_pkg;

  // Grid geometry
  localparam int GRID_COLS  = 64;
  localparam int COL_W      = 6;
  localparam int WIDTH_W    = 7;
  localparam int ROW_W      = 10;
  localparam int MAX_RADIUS = 7;
  localparam int RAD_W      = 3;
  localparam int DIST_W     = 4;

  // Back end window: rows within two radii of the newest one, and one group per column offset
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int NUM_GROUPS = MAX_RADIUS + 1;

  // Cell and configuration fields
  localparam int OCC_W      = 8;
  localparam int THR_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_MAX    = 3'd7;

  // Register reset values
  localparam logic [THR_W-1:0]   RST_THRESHOLD  = 7'd50;
  localparam logic [RAD_W-1:0]   RST_RADIUS     = 3'd2;
  localparam logic [WIDTH_W-1:0] RST_GRID_WIDTH = 7'd64;
  localparam logic               RST_BOX_ENABLE = 1'b1;
  localparam logic [COL_W-1:0]   RST_COL_MIN    = 6'd0;
  localparam logic [COL_W-1:0]   RST_COL_MAX    = 6'd63;
  localparam logic [ROW_W-1:0]   RST_ROW_MIN    = 10'd0;
  localparam logic [ROW_W-1:0]   RST_ROW_MAX    = 10'd1023;

  // One finished row handed from front to back
  typedef struct packed {
    logic [GRID_COLS-1:0] bits;
    logic [ROW_W-1:0]     row;
    logic                 last_cell;
    logic [RAD_W-1:0]     radius;
    logic [WIDTH_W-1:0]   width;
  } job_t;

  // True when column offset k and row distance gap lie inside the disc of radius r
  function automatic logic in_disc(input logic [RAD_W-1:0]  r,
                                   input logic [DIST_W-1:0] gap,
                                   input logic [RAD_W-1:0]  k);
    logic [8:0] lhs;
    logic [5:0] rr;
    lhs = {1'b0, 8'(gap) * 8'(gap)} + {3'b0, 6'(k) * 6'(k)};
    rr  = 6'(r) * 6'(r);
    return lhs <= {3'b0, rr};
  endfunction

endpackage

/* src/ogi_if.sv */
// Channel interfaces: cell input, row mask output and configuration write.
// Depends on ogi_pkg for field widths.
`timescale 1ns / 1ps

interface ogi_cell_if;
  logic                              valid;
  logic                              ready;
  logic signed [ogi_pkg::OCC_W-1:0]  occupancy;
  logic                              end_of_grid;

  modport source (output valid, occupancy, end_of_grid, input ready);
  modport sink   (input valid, occupancy, end_of_grid, output ready);
endinterface

interface ogi_row_if;
  logic                              valid;
  logic                              ready;
  logic [ogi_pkg::ROW_W-1:0]         row_number;
  logic [ogi_pkg::GRID_COLS-1:0]     blocked_bits;
  logic                              last_row;

  modport source (output valid, row_number, blocked_bits, last_row, input ready);
  modport sink   (input valid, row_number, blocked_bits, last_row, output ready);
endinterface

interface ogi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ogi_pkg::CFG_IDX_W-1:0]     index;
  logic [ogi_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/occupancy_grid_inflation.sv */
// Occupancy grid inflation: streaming disc dilation of obstacle cells into row mask words.
// Depends on ogi_pkg, ogi_if, ogi_front, ogi_queue and ogi_back.
//
// Channels: cell_i takes one occupancy cell per cycle in raster order, end_of_grid set on
// the final cell. row_o gives one 64-bit blocked mask per row, bit c for column c, with
// last_row set on the final row. cfg_i writes a register (index, data) and is always ready.
// Throughput: one cell per cycle. A row n >= radius ending mid-grid yields one mask word;
// the final cell yields up to radius+1 words, sent one per cycle by the back end
// sequencer while row_o takes them; a four-entry job queue takes the rows that finish
// meanwhile, so cells stall only once it fills, as with rows of one or two cells right
// after a grid end. A mask word for row o follows the cell that completes row o+radius
// through the queue, the window and sequencer, stage one and the output register.
// The dilation uses a window of the last fifteen base rows held in flip-flops.
// When row_o is stalled the output register holds its word, the two internal stages
// fill, then the queue fills, and only then is cell_i.ready pulled low.
// Reset clears counters, the row being built, the window valid bits and the queue, and
// loads the documented register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module occupancy_grid_inflation (
  input  logic     clk_i,
  input  logic     rst_ni,
  ogi_cell_if.sink cell_i,
  ogi_cfg_if.sink  cfg_i,
  ogi_row_if.source row_o
);

  ogi_pkg::job_t push_job, pop_job;
  logic          push_valid, push_ready, pop_valid, pop_ready;

  ogi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cell_i      (cell_i),
    .cfg_i       (cfg_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  ogi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  ogi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .row_o       (row_o)
  );

endmodule

/* src/ogi_front.sv */
// Front end: configuration registers, cell classification and row assembly.
// Depends on ogi_pkg and ogi_if; emits one job per finished row.
`timescale 1ns / 1ps

module ogi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ogi_cell_if.sink      cell_i,
  ogi_cfg_if.sink       cfg_i,
  output ogi_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);

  logic [ogi_pkg::THR_W-1:0]     thr_q;
  logic [ogi_pkg::RAD_W-1:0]     rad_q;
  logic [ogi_pkg::WIDTH_W-1:0]   gw_q;
  logic                          box_en_q;
  logic [ogi_pkg::COL_W-1:0]     cmin_q, cmax_q;
  logic [ogi_pkg::ROW_W-1:0]     rmin_q, rmax_q;

  logic [ogi_pkg::GRID_COLS-1:0] bits_q;
  logic [ogi_pkg::COL_W-1:0]     col_q;
  logic [ogi_pkg::ROW_W-1:0]     row_q;

  logic [ogi_pkg::WIDTH_W-1:0]   w_eff;
  logic [ogi_pkg::RAD_W-1:0]     r_eff;
  logic                          occ_neg, occ_over, out_box, mark, row_end, accept;
  logic [ogi_pkg::GRID_COLS-1:0] bits_set;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ogi_pkg::RST_THRESHOLD;
      rad_q    <= ogi_pkg::RST_RADIUS;
      gw_q     <= ogi_pkg::RST_GRID_WIDTH;
      box_en_q <= ogi_pkg::RST_BOX_ENABLE;
      cmin_q   <= ogi_pkg::RST_COL_MIN;
      cmax_q   <= ogi_pkg::RST_COL_MAX;
      rmin_q   <= ogi_pkg::RST_ROW_MIN;
      rmax_q   <= ogi_pkg::RST_ROW_MAX;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ogi_pkg::REG_THRESHOLD:  thr_q    <= cfg_i.data[ogi_pkg::THR_W-1:0];
        ogi_pkg::REG_RADIUS:     rad_q    <= cfg_i.data[ogi_pkg::RAD_W-1:0];
        ogi_pkg::REG_GRID_WIDTH: gw_q     <= cfg_i.data[ogi_pkg::WIDTH_W-1:0];
        ogi_pkg::REG_BOX_ENABLE: box_en_q <= cfg_i.data[0];
        ogi_pkg::REG_COL_MIN:    cmin_q   <= cfg_i.data[ogi_pkg::COL_W-1:0];
        ogi_pkg::REG_COL_MAX:    cmax_q   <= cfg_i.data[ogi_pkg::COL_W-1:0];
        ogi_pkg::REG_ROW_MIN:    rmin_q   <= cfg_i.data[ogi_pkg::ROW_W-1:0];
        ogi_pkg::REG_ROW_MAX:    rmax_q   <= cfg_i.data[ogi_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and radius into their usable ranges
  always_comb begin
    if (gw_q == '0) begin
      w_eff = ogi_pkg::WIDTH_W'(1);
    end else if (gw_q > ogi_pkg::WIDTH_W'(ogi_pkg::GRID_COLS)) begin
      w_eff = ogi_pkg::WIDTH_W'(ogi_pkg::GRID_COLS);
    end else begin
      w_eff = gw_q;
    end
    r_eff = (rad_q == '0) ? ogi_pkg::RAD_W'(1) : rad_q;
  end

  // Classify the cell: unknown, above threshold or outside the box
  assign occ_neg  = cell_i.occupancy[ogi_pkg::OCC_W-1];
  assign occ_over = !occ_neg && (cell_i.occupancy[ogi_pkg::OCC_W-2:0] > thr_q);
  assign out_box  = box_en_q && ((col_q < cmin_q) || (col_q > cmax_q) ||
                                 (row_q < rmin_q) || (row_q > rmax_q));
  assign mark     = (occ_neg || occ_over || out_box) && ({1'b0, col_q} < w_eff);
  assign row_end  = (({1'b0, col_q} + ogi_pkg::WIDTH_W'(1)) >= w_eff) || cell_i.end_of_grid;
  assign bits_set = bits_q | (ogi_pkg::GRID_COLS'(mark) << col_q);

  // Stall cells while the job queue is full
  assign cell_i.ready = job_ready_i;
  assign accept       = cell_i.valid && job_ready_i;
  assign job_valid_o  = accept && row_end;

  always_comb begin
    job_o.bits      = bits_set;
    job_o.row       = row_q;
    job_o.last_cell = cell_i.end_of_grid;
    job_o.radius    = r_eff;
    job_o.width     = w_eff;
  end

  // Advance column and row counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (accept) begin
      if (row_end) begin
        bits_q <= '0;
        col_q  <= '0;
        row_q  <= cell_i.end_of_grid ? '0 : row_q + ogi_pkg::ROW_W'(1);
      end else begin
        bits_q <= bits_set;
        col_q  <= col_q + ogi_pkg::COL_W'(1);
      end
    end
  end

endmodule

/* src/ogi_queue.sv */
// Short job queue between the front and back ends.
// Depends on ogi_pkg for the job type and depth.
`timescale 1ns / 1ps

module ogi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ogi_pkg::job_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output ogi_pkg::job_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);

  ogi_pkg::job_t                entry_q [ogi_pkg::QUEUE_DEPTH];
  logic [ogi_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [ogi_pkg::QCNT_W-1:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = (cnt_q != ogi_pkg::QCNT_W'(ogi_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + ogi_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + ogi_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + ogi_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - ogi_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* src/ogi_back.sv */
// Back end: row window, emission sequencer and two-stage disc dilation pipeline.
// Depends on ogi_pkg and ogi_if; drives the row mask output channel.
`timescale 1ns / 1ps

module ogi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ogi_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  ogi_row_if.source     row_o
);

  // Window of recent base rows, newest at position 0
  logic [ogi_pkg::GRID_COLS-1:0] win_q [ogi_pkg::WIN_DEPTH];
  logic [ogi_pkg::WIN_DEPTH-1:0] win_vld_q;

  // Sequencer for the job in hand
  logic                          act_q;
  logic [ogi_pkg::RAD_W-1:0]     j_q;
  logic [ogi_pkg::ROW_W-1:0]     cur_row_q;
  logic                          cur_last_q;
  logic [ogi_pkg::RAD_W-1:0]     cur_r_q;
  logic [ogi_pkg::WIDTH_W-1:0]   cur_w_q;

  // Stage one: vertical OR per column offset
  logic                          s1_vld_q;
  logic [ogi_pkg::GRID_COLS-1:0] s1_grp_q [ogi_pkg::NUM_GROUPS];
  logic [ogi_pkg::ROW_W-1:0]     s1_row_q;
  logic                          s1_last_q;
  logic [ogi_pkg::WIDTH_W-1:0]   s1_w_q;

  // Output register
  logic                          out_vld_q;
  logic [ogi_pkg::ROW_W-1:0]     out_row_q;
  logic [ogi_pkg::GRID_COLS-1:0] out_bits_q;
  logic                          out_last_q;

  logic                          out_take, s1_free, issue, last_issue, pop;
  logic                          row_ge_r, has_emit;
  logic [ogi_pkg::RAD_W-1:0]     j_start;
  logic [ogi_pkg::GRID_COLS-1:0] grp [ogi_pkg::NUM_GROUPS];
  logic [ogi_pkg::GRID_COLS-1:0] acc, mask;
  logic [ogi_pkg::DIST_W-1:0]    row_gap;

  // Pipeline flow control
  assign out_take    = !out_vld_q || row_o.ready;
  assign s1_free     = !s1_vld_q || out_take;
  assign issue       = act_q && s1_free;
  assign last_issue  = issue && (!cur_last_q || (j_q == '0));
  assign job_ready_o = !act_q || last_issue;
  assign pop         = job_valid_i && job_ready_o;

  // Emissions for a new job: one row a radius back, or every pending row at the grid end
  assign row_ge_r = (job_i.row >= ogi_pkg::ROW_W'(job_i.radius));
  assign has_emit = row_ge_r || job_i.last_cell;
  assign j_start  = (job_i.last_cell && !row_ge_r) ? job_i.row[ogi_pkg::RAD_W-1:0]
                                                   : job_i.radius;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      j_q       <= '0;
      win_vld_q <= '0;
    end else if (pop) begin
      act_q     <= has_emit;
      j_q       <= j_start;
      // Row zero opens a fresh grid: older rows fall out of reach
      win_vld_q <= (job_i.row == '0) ? ogi_pkg::WIN_DEPTH'(1)
                                     : {win_vld_q[ogi_pkg::WIN_DEPTH-2:0], 1'b1};
    end else if (issue) begin
      if (last_issue) begin
        act_q <= 1'b0;
      end else begin
        j_q <= j_q - ogi_pkg::RAD_W'(1);
      end
    end
  end

  // Shift the new row into the window and hold the job fields
  always_ff @(posedge clk_i) begin
    if (pop) begin
      win_q[0] <= job_i.bits;
      for (int i = 1; i < ogi_pkg::WIN_DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
      cur_row_q  <= job_i.row;
      cur_last_q <= job_i.last_cell;
      cur_r_q    <= job_i.radius;
      cur_w_q    <= job_i.width;
    end
  end

  // Gather window rows by the column reach that their row distance allows
  always_comb begin
    for (int k = 0; k < ogi_pkg::NUM_GROUPS; k++) begin
      grp[k] = '0;
    end
    row_gap = '0;
    for (int p = 0; p < ogi_pkg::WIN_DEPTH; p++) begin
      row_gap = ({1'b0, j_q} >= ogi_pkg::DIST_W'(p)) ? ({1'b0, j_q} - ogi_pkg::DIST_W'(p))
                                                      : (ogi_pkg::DIST_W'(p) - {1'b0, j_q});
      for (int k = 0; k < ogi_pkg::NUM_GROUPS; k++) begin
        if (win_vld_q[p] && ogi_pkg::in_disc(cur_r_q, row_gap, ogi_pkg::RAD_W'(k))) begin
          grp[k] = grp[k] | win_q[p];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int k = 0; k < ogi_pkg::NUM_GROUPS; k++) begin
        s1_grp_q[k] <= grp[k];
      end
      s1_row_q  <= cur_row_q - ogi_pkg::ROW_W'(j_q);
      s1_last_q <= cur_last_q && (j_q == '0);
      s1_w_q    <= cur_w_q;
    end
  end

  // Spread each group sideways by its offset and clip to the grid width
  always_comb begin
    acc = '0;
    for (int k = 0; k < ogi_pkg::NUM_GROUPS; k++) begin
      acc = acc | (s1_grp_q[k] << k) | (s1_grp_q[k] >> k);
    end
    for (int c = 0; c < ogi_pkg::GRID_COLS; c++) begin
      mask[c] = (ogi_pkg::WIDTH_W'(c) < s1_w_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_vld_q) begin
      out_row_q  <= s1_row_q;
      out_bits_q <= acc & mask;
      out_last_q <= s1_last_q;
    end
  end

  assign row_o.valid        = out_vld_q;
  assign row_o.row_number   = out_row_q;
  assign row_o.blocked_bits = out_bits_q;
  assign row_o.last_row     = out_last_q;

`ifndef NO_ASSERTIONS
  a_j_within_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (ogi_pkg::ROW_W'(j_q) <= cur_row_q))
    else $error("emission row before the top of the grid");

  a_mid_grid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !cur_last_q) |-> (j_q == cur_r_q))
    else $error("mid-grid job not emitting one radius back");

  a_issue_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_vld_q)
    else $error("issued emission lost before stage one");

  a_newest_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> win_vld_q[0])
    else $error("active job without its own row in the window");
`endif

endmodule

/* test/occupancy_grid_inflation_test.sv */
// Self-checking testbench for occupancy_grid_inflation: a short stimulus table, then random grids.
// Depends on ogi_pkg and ogi_if; expected words come from a local predictor or the table.
`timescale 1ns / 1ps

module occupancy_grid_inflation_test;
  import ogi_pkg::*;

  localparam int ROW_STORE_DEPTH = 2 * MAX_RADIUS + 2;
  localparam int ROW_LIMIT       = 1 << ROW_W;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 12;
  localparam int PHASE_CELLS     = 40;
  localparam int PLAN_LEN        = 42;

  typedef struct packed {
    logic [ROW_W-1:0]     row_number;
    logic [GRID_COLS-1:0] blocked_bits;
    logic                 last_row;
  } mask_word_t;

  typedef enum bit {STEP_CELL, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    logic signed [OCC_W-1:0] occupancy;
    logic                   end_of_grid;
    logic                   known;
    mask_word_t             word;
  } step_t;

  // Directed table; known rows carry their expected mask word in the table itself
  step_t plan [PLAN_LEN] = '{
    // reset settings: one cell grids, radius 2 gives bits 0..2 around column 0
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'h80, 1'b1, 1'b1, '{10'd0, 64'd7, 1'b1}},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'h7F, 1'b1, 1'b1, '{10'd0, 64'd7, 1'b1}},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b1, '{10'd0, 64'd0, 1'b1}},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd50, 1'b1, 1'b1, '{10'd0, 64'd0, 1'b1}},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd51, 1'b1, 1'b1, '{10'd0, 64'd7, 1'b1}},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'hFF, 1'b1, 1'b1, '{10'd0, 64'd7, 1'b1}},
    // empty column range: every cell is outside the box
    '{STEP_WRITE, REG_COL_MIN,    10'd5,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_COL_MAX,    10'd3,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b1, '{10'd0, 64'd7, 1'b1}},
    // largest radius, threshold 100, narrow grid
    '{STEP_WRITE, REG_COL_MIN,    10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_COL_MAX,    10'd63,  8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_GRID_WIDTH, 10'd3,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_RADIUS,     10'd7,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_THRESHOLD,  10'd100, 8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd101, 1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd100, 1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'h80, 1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b0, '0},
    // radius 0 and width 0 act as 1, zero threshold, row range 1..2
    '{STEP_WRITE, REG_RADIUS,     10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_GRID_WIDTH, 10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_ROW_MIN,    10'd1,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_ROW_MAX,    10'd2,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd1,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b0, '0},
    // oversized width acts as the full grid; end the grid in mid-row
    '{STEP_WRITE, REG_GRID_WIDTH, 10'd127, 8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_BOX_ENABLE, 10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_RADIUS,     10'd1,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd1,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b0, '0},
    // width lowered below the current column while a row is open
    '{STEP_WRITE, REG_GRID_WIDTH, 10'd8,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd5,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_WRITE, REG_GRID_WIDTH, 10'd2,   8'd0,  1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd127, 1'b0, 1'b0, '0},
    '{STEP_CELL,  REG_THRESHOLD,  10'd0,   8'd0,  1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  ogi_cell_if cell_bus ();
  ogi_cfg_if  cfg_bus ();
  ogi_row_if  row_bus ();

  occupancy_grid_inflation u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cell_i (cell_bus),
    .cfg_i  (cfg_bus),
    .row_o  (row_bus)
  );

  // Register copy held by the predictor
  logic [THR_W-1:0]   thr_q   = RST_THRESHOLD;
  logic [RAD_W-1:0]   rad_q   = RST_RADIUS;
  logic [WIDTH_W-1:0] width_q = RST_GRID_WIDTH;
  logic               box_q   = RST_BOX_ENABLE;
  logic [COL_W-1:0]   cmin_q  = RST_COL_MIN;
  logic [COL_W-1:0]   cmax_q  = RST_COL_MAX;
  logic [ROW_W-1:0]   rmin_q  = RST_ROW_MIN;
  logic [ROW_W-1:0]   rmax_q  = RST_ROW_MAX;

  // Grid state held by the predictor
  logic [GRID_COLS-1:0] base_rows [ROW_STORE_DEPTH] = '{default: '0};
  logic [GRID_COLS-1:0] open_row_bits = '0;
  int                   col_pos = 0;
  int                   row_pos = 0;

  mask_word_t expected_words [$];
  int         mismatches    = 0;
  int         send_idle_pct = 37;
  int         recv_idle_pct = 61;

  function automatic int active_width();
    if (width_q < 1) return 1;
    if (width_q > GRID_COLS) return GRID_COLS;
    return int'(width_q);
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD:  thr_q   = data[THR_W-1:0];
      REG_RADIUS:     rad_q   = data[RAD_W-1:0];
      REG_GRID_WIDTH: width_q = data[WIDTH_W-1:0];
      REG_BOX_ENABLE: box_q   = data[0];
      REG_COL_MIN:    cmin_q  = data[COL_W-1:0];
      REG_COL_MAX:    cmax_q  = data[COL_W-1:0];
      REG_ROW_MIN:    rmin_q  = data[ROW_W-1:0];
      default:        rmax_q  = data[ROW_W-1:0];
    endcase
  endfunction

  // OR together the base rows around row o, each shifted across the disc's half chord
  function automatic logic [GRID_COLS-1:0] dilate_row(int o, int newest, int r, int w);
    logic [GRID_COLS-1:0] acc;
    logic [GRID_COLS-1:0] b;
    int s, h, d, k;
    acc = '0;
    for (d = -r; d <= r; d++) begin
      s = o + d;
      if (s < 0 || s > newest) continue;
      b = base_rows[s % ROW_STORE_DEPTH];
      h = 0;
      while ((h + 1) * (h + 1) + d * d <= r * r) h++;
      for (k = 0; k <= h; k++) acc |= (b << k) | (b >> k);
    end
    if (w < GRID_COLS) acc &= (64'd1 << w) - 64'd1;
    return acc;
  endfunction

  function automatic void queue_word(int o, int newest, int r, int w, bit last, bit keep);
    mask_word_t word;
    if (keep) begin
      word.row_number   = ROW_W'(o);
      word.blocked_bits = dilate_row(o, newest, r, w);
      word.last_row     = last;
      expected_words.insert(expected_words.size(), word);
    end
  endfunction

  // Advance the predicted grid by one cell; keep selects whether the words are queued
  function automatic void predict_cell(logic signed [OCC_W-1:0] occ, logic eog, bit keep);
    int w, r, col, row, o, v;
    bit blocked;
    w = active_width();
    r = (rad_q < 1) ? 1 : int'(rad_q);
    col = col_pos;
    row = row_pos;
    v = occ;
    blocked = (v < 0) || (v > int'(thr_q));
    if (box_q && (col < int'(cmin_q) || col > int'(cmax_q) ||
                  row < int'(rmin_q) || row > int'(rmax_q)))
      blocked = 1'b1;
    if (blocked && col < w) open_row_bits[col] = 1'b1;
    if (col + 1 >= w || eog) begin
      base_rows[row % ROW_STORE_DEPTH] = open_row_bits;
      open_row_bits = '0;
      col_pos = 0;
      if (row - r >= 0) queue_word(row - r, row, r, w, eog && (row - r == row), keep);
      if (eog) begin
        o = (row - r + 1 < 0) ? 0 : row - r + 1;
        for (; o <= row; o++) queue_word(o, row, r, w, o == row, keep);
        row_pos = 0;
      end else begin
        row_pos = (row + 1) % ROW_LIMIT;
      end
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // Mostly free cells at or below the threshold, the rest obstacles, unknowns and raw noise
  function automatic logic signed [OCC_W-1:0] pick_occupancy();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return OCC_W'($urandom_range(0, thr_q));
      6:                return OCC_W'($urandom_range(0, 100));
      7:                return OCC_W'($urandom_range(128, 255));
      8:                return OCC_W'($urandom_range(101, 127));
      default:          return OCC_W'($urandom);
    endcase
  endfunction

  // Offer one cell, with random gaps before it, and hold it until taken
  task automatic send_cell(logic signed [OCC_W-1:0] occ, logic eog);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cell_bus.valid       <= 1'b1;
    cell_bus.occupancy   <= occ;
    cell_bus.end_of_grid <= eog;
    do @(posedge clk); while (!cell_bus.ready);
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cell_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    apply_setting(idx, data);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Take mask words and compare each against the oldest expectation
  initial begin : row_sink
    mask_word_t got;
    mask_word_t want;
    row_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (row_bus.valid && row_bus.ready) begin
        got = '{row_bus.row_number, row_bus.blocked_bits, row_bus.last_row};
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected mask word, row %0d bits %h last %0b",
                   $time, got.row_number, got.blocked_bits, got.last_row);
        end else begin
          want = expected_words.pop_front();
          if (got.row_number !== want.row_number) begin
            mismatches++;
            $display("%0t: row_number expected %0d actual %0d",
                     $time, want.row_number, got.row_number);
          end
          if (got.blocked_bits !== want.blocked_bits) begin
            mismatches++;
            $display("%0t: blocked_bits of row %0d expected %h actual %h",
                     $time, want.row_number, want.blocked_bits, got.blocked_bits);
          end
          if (got.last_row !== want.last_row) begin
            mismatches++;
            $display("%0t: last_row of row %0d expected %0b actual %0b",
                     $time, want.row_number, want.last_row, got.last_row);
          end
        end
      end
      if (rst_n) row_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus
  initial begin : cell_source
    int phase, sent, budget, n_rows, total, i, w;
    bit cut;
    logic signed [OCC_W-1:0] occ;
    logic [THR_W-1:0]   thr_v;
    logic [WIDTH_W-1:0] width_v;
    rst_n                <= 1'b0;
    cell_bus.valid       <= 1'b0;
    cell_bus.occupancy   <= '0;
    cell_bus.end_of_grid <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_THRESHOLD;
    cfg_bus.data         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == STEP_WRITE) begin
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_cell(plan[i].occupancy, plan[i].end_of_grid);
        predict_cell(plan[i].occupancy, plan[i].end_of_grid, !plan[i].known);
        if (plan[i].known) expected_words.insert(expected_words.size(), plan[i].word);
      end
    end

    // Random phases, each under fresh settings and a fixed number of cells
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 4)
        0:       begin send_idle_pct = 37; recv_idle_pct = 61; end
        1:       begin send_idle_pct = 61; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      case ($urandom_range(3))
        0:       thr_v = 7'd0;
        1:       thr_v = 7'd100;
        2:       thr_v = 7'd127;
        default: thr_v = THR_W'($urandom_range(0, 100));
      endcase
      case ($urandom_range(9))
        0:       width_v = 7'd64;
        1:       width_v = 7'd127;
        2:       width_v = 7'd0;
        3:       width_v = 7'd1;
        default: width_v = WIDTH_W'($urandom_range(2, 12));
      endcase
      write_reg(REG_THRESHOLD, {3'($urandom), thr_v});
      write_reg(REG_RADIUS, {7'($urandom), 3'($urandom_range(0, 7))});
      write_reg(REG_GRID_WIDTH, {3'($urandom), width_v});
      write_reg(REG_BOX_ENABLE, {9'($urandom), 1'($urandom)});
      write_reg(REG_COL_MIN, {4'($urandom), ($urandom_range(3) == 0) ?
                              6'($urandom) : 6'($urandom_range(0, 3))});
      write_reg(REG_COL_MAX, {4'($urandom), ($urandom_range(3) == 0) ?
                              6'($urandom) : 6'($urandom_range(8, 63))});
      write_reg(REG_ROW_MIN, ($urandom_range(3) == 0) ?
                             10'($urandom) : 10'($urandom_range(0, 3)));
      write_reg(REG_ROW_MAX, ($urandom_range(3) == 0) ?
                             10'($urandom) : 10'($urandom_range(4, 1023)));

      budget = PHASE_CELLS;
      sent   = 0;
      while (sent < budget) begin
        w      = active_width();
        n_rows = $urandom_range(1, (w > 16) ? 2 : 10);
        total  = n_rows * w;
        // early end in mid-grid now and then
        if ($urandom_range(9) == 0) total = $urandom_range(1, total);
        // trim the last grid of a phase to the cell budget
        if (sent + total > budget) total = budget - sent;
        // sometimes leave the last grid of a phase open across the next writes
        cut = (sent + total >= budget) && ($urandom_range(2) == 0);
        for (i = 0; i < total; i++) begin
          occ = pick_occupancy();
          send_cell(occ, (i == total - 1) && !cut);
          predict_cell(occ, (i == total - 1) && !cut, 1'b1);
          sent++;
        end
      end
    end

    // Drain and report
    cell_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
